@@ src/morf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package morf_pkg;

  typedef enum logic [1:0] {
    OP_POINT = 2'd0,
    OP_FILL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SEND  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL_RD,
    S_FILL_WR,
    S_SEND_RD,
    S_SEND_EMIT
  } state_t;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;

  typedef struct packed {
    op_t        op;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic       pixel_on;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       is_data;
    logic       frame_end;
  } stream_stat_t;

endpackage

`default_nettype wire

@@ src/morf_stream.sv @@
`timescale 1ns / 1ps
`default_nettype none

module morf_stream import morf_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8,
  parameter int PW      = 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  output logic [PW-1:0]      page,
  output logic [7:0]         col,
  output stream_stat_t       stat
);

  localparam int OW = $clog2(COLUMNS + 3);
  localparam logic [OW-1:0] OFF_LAST  = OW'(COLUMNS + 2);
  localparam logic [OW-1:0] OFF_DATA  = OW'(3);
  localparam logic [OW-1:0] OFF_LO    = OW'(1);
  localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);

  logic [OW-1:0] off;
  logic [OW-1:0] off_next;
  logic [PW-1:0] page_next;

  always_comb begin
    off_next  = off + OW'(1);
    page_next = page;
    if (off == OFF_LAST) begin
      off_next  = '0;
      page_next = (page == PAGE_LAST) ? '0 : page + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off  <= '0;
      page <= '0;
    end else if (step) begin
      off  <= off_next;
      page <= page_next;
    end
  end

  always_comb begin
    logic [OW-1:0] data_off;
    data_off       = off - OFF_DATA;
    col            = 8'(data_off);
    stat.is_data   = (off >= OFF_DATA);
    stat.frame_end = (off == OFF_LAST) && (page == PAGE_LAST);
    if (off == '0) begin
      stat.cmd_byte = CMD_PAGE_BASE + 8'(page);
    end else if (off == OFF_LO) begin
      stat.cmd_byte = CMD_COL_LO;
    end else begin
      stat.cmd_byte = CMD_COL_HI;
    end
  end

endmodule

`default_nettype wire

@@ src/mono_oled_framebuffer_refresh_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Frame store and refresh byte source for a page-mode monochrome display.
// Input channel: an item on item is taken at a clock edge with start high
// and busy low. Ops: draw point, fill rectangle, clear store, send byte.
// Result channel: a send item yields one result on result, marked by done
// for exactly one cycle; other ops yield nothing. The receiver cannot stall.
// Op sequences after the accepting edge:
//   point: one read-modify-write of the single-port store (read, then write).
//   fill:  one read-modify-write per byte touched (columns times pages in range);
//          an empty or off-screen rectangle leaves the core idle.
//   clear: every store entry is written to zero, one store entry a cycle.
//   send:  the byte is read in S_SEND_RD and emitted from S_SEND_EMIT;
//          busy is low while done is high, so a new item can be taken.
// The store has a single read/write port, shared by clear, fill and send.
// Reset: the refresh position goes to the start of a frame and the store is
// swept to zero with busy high.
module mono_oled_framebuffer_refresh_core import morf_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire item_t item,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [7:0]    X_MAX     = 8'(COLUMNS - 1);
  localparam logic [7:0]    Y_MAX     = 8'(PAGES * 8 - 1);
  localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);

  state_t state;
  state_t state_next;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] clr_addr_next;
  logic          done_next;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic [7:0]    fx;
  logic [7:0]    x0;
  logic [7:0]    x1;
  logic [7:0]    y0;
  logic [7:0]    y1;
  logic [PW-1:0] fb;
  logic          on;

  logic          accept;
  logic [7:0]    ax1;
  logic [7:0]    ay1;
  logic          fill_empty;
  logic [PW-1:0] y0_blk;
  logic [PW-1:0] y1_blk;
  logic          fill_last;
  logic [7:0]    mask;
  logic [AW-1:0] fill_addr;
  logic [AW-1:0] send_addr;
  logic          step;

  logic [PW-1:0] send_page;
  logic [7:0]    send_col;
  stream_stat_t  stat;

  morf_stream #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .PW      (PW)
  ) u_stream (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .page (send_page),
    .col  (send_col),
    .stat (stat)
  );

  assign accept = (state == S_IDLE) && start;

  // A point is a one-pixel fill; clipping the far corner makes an off-screen
  // point come out empty.
  always_comb begin
    logic [7:0] xb;
    logic [7:0] yb;
    xb         = (item.op == OP_POINT) ? item.x_a : item.x_b;
    yb         = (item.op == OP_POINT) ? item.y_a : item.y_b;
    ax1        = (xb > X_MAX) ? X_MAX : xb;
    ay1        = (yb > Y_MAX) ? Y_MAX : yb;
    fill_empty = (item.x_a > ax1) || (item.y_a > ay1);
  end

  assign y0_blk    = y0[3 +: PW];
  assign y1_blk    = y1[3 +: PW];
  assign fill_last = (fx == x1) && (fb == y1_blk);

  // Rows of the current 8-row block that fall inside the rectangle.
  always_comb begin
    logic [2:0] lo_k;
    logic [2:0] hi_k;
    lo_k = (fb == y0_blk) ? y0[2:0] : 3'd0;
    hi_k = (fb == y1_blk) ? y1[2:0] : 3'd7;
    for (int i = 0; i < 8; i++) begin
      mask[i] = (3'(7 - i) >= lo_k) && (3'(7 - i) <= hi_k);
    end
  end

  assign fill_addr = AW'(PAGE_LAST - fb) * COLS_A + AW'(fx);
  assign send_addr = AW'(send_page) * COLS_A + AW'(send_col);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (item.op)
            OP_POINT, OP_FILL: state_next = fill_empty ? S_IDLE : S_FILL_RD;
            OP_CLEAR:          state_next = S_CLEAR;
            OP_SEND:           state_next = S_SEND_RD;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_FILL_RD:   state_next = S_FILL_WR;
      S_FILL_WR:   state_next = fill_last ? S_IDLE : S_FILL_RD;
      S_SEND_RD:   state_next = S_SEND_EMIT;
      S_SEND_EMIT: state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != S_IDLE);
    mem_we        = 1'b0;
    mem_addr      = fill_addr;
    mem_wdata     = on ? (rd_data | mask) : (rd_data & ~mask);
    clr_addr_next = clr_addr;
    step          = 1'b0;
    done_next     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_addr      = clr_addr;
        mem_wdata     = 8'h00;
        clr_addr_next = (clr_addr == ADDR_LAST) ? '0 : clr_addr + AW'(1);
      end
      S_FILL_WR: mem_we = 1'b1;
      S_SEND_RD: mem_addr = send_addr;
      S_SEND_EMIT: begin
        step      = 1'b1;
        done_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // Walk columns inside, 8-row blocks outside.
  always_ff @(posedge clk) begin
    if (accept) begin
      fx <= item.x_a;
      x0 <= item.x_a;
      x1 <= ax1;
      y0 <= item.y_a;
      y1 <= ay1;
      fb <= item.y_a[3 +: PW];
      on <= item.pixel_on;
    end else if (state == S_FILL_WR) begin
      if (fx == x1) begin
        fx <= x0;
        fb <= fb + PW'(1);
      end else begin
        fx <= fx + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEND_EMIT) begin
      result.out_byte  <= stat.is_data ? rd_data : stat.cmd_byte;
      result.is_data   <= stat.is_data;
      result.frame_end <= stat.frame_end;
    end
  end

endmodule

`default_nettype wire
